// File: hw/rtl/tsrp_pkg.sv
`default_nettype none

package tsrp_pkg;

    // event codes
    localparam logic [2:0] MODE_CREATE  = 3'd0;
    localparam logic [2:0] MODE_DESTROY = 3'd1;
    localparam logic [2:0] MODE_WAKE    = 3'd2;
    localparam logic [2:0] MODE_YIELD   = 3'd3;
    localparam logic [2:0] MODE_EXIT    = 3'd4;
    localparam logic [2:0] MODE_SLEEP   = 3'd5;
    localparam logic [2:0] MODE_TICK    = 3'd6;

    // result status codes
    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_IGNORED  = 2'd1;
    localparam logic [1:0] STATUS_OCCUPIED = 2'd2;

    // task states
    localparam logic [1:0] TS_READY  = 2'd0;
    localparam logic [1:0] TS_RUN    = 2'd1;
    localparam logic [1:0] TS_SLEEP  = 2'd2;
    localparam logic [1:0] TS_ZOMBIE = 2'd3;

    // fixed part of a slot entry
    localparam int PRIO_W = 8;
    localparam int CPU_W  = 32;
    localparam int WAKE_W = 64;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  task_slot;
        logic [7:0]  task_priority;
        logic [31:0] sleep_ticks;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  running_task;
        logic        running_idle;
        logic        switched;
        logic [63:0] tick_count;
        logic [31:0] switch_count;
        logic [31:0] idle_count;
        logic [31:0] busy_count;
    } result_t;

    typedef enum logic [28:0] {
        S_IDLE = 29'd1 << 0,
        S_DISP = 29'd1 << 1,
        S_RI_A = 29'd1 << 2,
        S_RI_B = 29'd1 << 3,
        S_RI_C = 29'd1 << 4,
        S_RI_D = 29'd1 << 5,
        S_RR_A = 29'd1 << 6,
        S_RR_B = 29'd1 << 7,
        S_RR_C = 29'd1 << 8,
        S_SR_A = 29'd1 << 9,
        S_SR_B = 29'd1 << 10,
        S_SR_C = 29'd1 << 11,
        S_SR_E = 29'd1 << 12,
        S_DS_B = 29'd1 << 13,
        S_WK_B = 29'd1 << 14,
        S_SL_B = 29'd1 << 15,
        S_SL_C = 29'd1 << 16,
        S_TK_A = 29'd1 << 17,
        S_TK_B = 29'd1 << 18,
        S_TK_C = 29'd1 << 19,
        S_TK_D = 29'd1 << 20,
        S_PK_A = 29'd1 << 21,
        S_PK_R = 29'd1 << 22,
        S_PK_B = 29'd1 << 23,
        S_PK_C = 29'd1 << 24,
        S_PK_D = 29'd1 << 25,
        S_UPD  = 29'd1 << 26,
        S_UP_B = 29'd1 << 27,
        S_DONE = 29'd1 << 28
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/task_scheduler_rr_priority.sv
`default_nettype none

// a guarded-off event passes from the dispatch state straight to the done state
// a tick walks the sleep list, re-walks it from the front to unlink each due sleeper and, in
// priority mode, scans the ready ring, one table read a step
// throughput: one event at a time, the next start is taken the cycle after done
// reset: control state, flags and counters clear at once; the slot table is not cleared
// and needs no clearing pass, the receiver cannot stall results
module task_scheduler_rr_priority #(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire tsrp_pkg::cmd_t   cmd,
    output logic                  done,
    output tsrp_pkg::result_t     result,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready
);

    localparam int SW       = $clog2(NUM_SLOTS);
    localparam int SV       = SW + 1;
    localparam int CPU_LO   = tsrp_pkg::PRIO_W;
    localparam int WAKE_LO  = CPU_LO + tsrp_pkg::CPU_W;
    localparam int NEXT_LO  = WAKE_LO + tsrp_pkg::WAKE_W;
    localparam int PREV_LO  = NEXT_LO + SW;
    localparam int SLINK_LO = PREV_LO + SW;
    localparam int EW       = SLINK_LO + SV;
    localparam logic [SV-1:0] NONE = SV'(NUM_SLOTS);

    tsrp_pkg::state_t state_reg, state_next;
    tsrp_pkg::state_t ri_ret_reg, ri_ret_next, rr_ret_reg, rr_ret_next;
    tsrp_pkg::state_t sr_ret_reg, sr_ret_next;
    tsrp_pkg::cmd_t   cmd_reg, cmd_next;

    logic [1:0]           status_reg, status_next;
    logic                 switched_reg, switched_next;
    logic                 policy_reg;
    logic [NUM_SLOTS-1:0] used_reg, used_next, queued_reg, queued_next;
    logic [1:0]           stat_reg [NUM_SLOTS];
    logic [1:0]           stat_next [NUM_SLOTS];
    logic [SW-1:0]        head_reg, head_next;
    logic                 empty_reg, empty_next;
    logic [SV-1:0]        sfirst_reg, sfirst_next, cur_reg, cur_next;
    logic [63:0]          tick_reg, tick_next;
    logic [31:0]          switch_reg, switch_next, idle_reg, idle_next;
    logic [31:0]          busy_cnt_reg, busy_cnt_next;
    logic [SW-1:0]        sub_reg, sub_next, tail_reg, tail_next;
    logic [SW-1:0]        rn_reg, rn_next, rp_reg, rp_next;
    logic [SV-1:0]        sp_prev_reg, sp_prev_next, sp_cur_reg, sp_cur_next;
    logic [SV-1:0]        sp_k_reg, sp_k_next;
    logic [SV-1:0]        wk_reg, wk_next, wk_nx_reg, wk_nx_next, wk_k_reg, wk_k_next;
    logic [SW-1:0]        best_reg, best_next, pc_reg, pc_next;
    logic [7:0]           bprio_reg, bprio_next;
    logic [31:0]          bcpu_reg, bcpu_next;
    logic [SV-1:0]        pk_k_reg, pk_k_next, pk_reg, pk_next;

    // slot table port
    logic          mem_we, mem_re;
    logic [SW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wmask, mem_wdata, mem_q;

    logic          accept;
    logic          cfg_wr;
    logic          slot_ok, cur_real;
    logic [SW-1:0] slot_ix, cur_ix;

    tsrp_ram #(
        .WIDTH(EW),
        .DEPTH(NUM_SLOTS)
    ) u_table (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wmask(mem_wmask),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_q)
    );

    assign busy     = (state_reg != tsrp_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign done     = (state_reg == tsrp_pkg::S_DONE);
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {31'd0, policy_reg} : 32'd0;
    assign slot_ok  = (32'(cmd_reg.task_slot) < NUM_SLOTS);
    assign slot_ix  = SW'(cmd_reg.task_slot);
    assign cur_ix   = cur_reg[SW-1:0];
    assign cur_real = (32'(cur_reg) < NUM_SLOTS) && used_reg[cur_ix];

    // result fields
    always_comb
    begin
        result.status       = status_reg;
        result.running_task = (32'(cur_reg) < NUM_SLOTS) ? 4'(cur_ix) : 4'd0;
        result.running_idle = !(32'(cur_reg) < NUM_SLOTS);
        result.switched     = switched_reg;
        result.tick_count   = tick_reg;
        result.switch_count = switch_reg;
        result.idle_count   = idle_reg;
        result.busy_count   = busy_cnt_reg;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        ri_ret_next   = ri_ret_reg;
        rr_ret_next   = rr_ret_reg;
        sr_ret_next   = sr_ret_reg;
        cmd_next      = cmd_reg;
        status_next   = status_reg;
        switched_next = switched_reg;
        used_next     = used_reg;
        queued_next   = queued_reg;
        stat_next     = stat_reg;
        head_next     = head_reg;
        empty_next    = empty_reg;
        sfirst_next   = sfirst_reg;
        cur_next      = cur_reg;
        tick_next     = tick_reg;
        switch_next   = switch_reg;
        idle_next     = idle_reg;
        busy_cnt_next = busy_cnt_reg;
        sub_next      = sub_reg;
        tail_next     = tail_reg;
        rn_next       = rn_reg;
        rp_next       = rp_reg;
        sp_prev_next  = sp_prev_reg;
        sp_cur_next   = sp_cur_reg;
        sp_k_next     = sp_k_reg;
        wk_next       = wk_reg;
        wk_nx_next    = wk_nx_reg;
        wk_k_next     = wk_k_reg;
        best_next     = best_reg;
        pc_next       = pc_reg;
        bprio_next    = bprio_reg;
        bcpu_next     = bcpu_reg;
        pk_k_next     = pk_k_reg;
        pk_next       = pk_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = '0;
        mem_raddr     = '0;
        mem_wmask     = '0;
        mem_wdata     = '0;

        case (state_reg)
            tsrp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd;
                    state_next = tsrp_pkg::S_DISP;
                end
            end

            // guard checks and first step of each event
            tsrp_pkg::S_DISP:
            begin
                status_next   = tsrp_pkg::STATUS_DONE;
                switched_next = 1'b0;
                state_next    = tsrp_pkg::S_DONE;
                case (cmd_reg.mode)
                    tsrp_pkg::MODE_CREATE:
                    begin
                        if (!slot_ok)
                        begin
                            status_next = tsrp_pkg::STATUS_IGNORED;
                        end
                        else if (used_reg[slot_ix])
                        begin
                            status_next = tsrp_pkg::STATUS_OCCUPIED;
                        end
                        else
                        begin
                            used_next[slot_ix]   = 1'b1;
                            stat_next[slot_ix]   = tsrp_pkg::TS_READY;
                            queued_next[slot_ix] = 1'b0;
                            mem_we    = 1'b1;
                            mem_waddr = slot_ix;
                            mem_wdata[0 +: tsrp_pkg::PRIO_W]       = cmd_reg.task_priority;
                            mem_wmask[0 +: tsrp_pkg::PRIO_W]       = '1;
                            mem_wmask[CPU_LO +: tsrp_pkg::CPU_W]   = '1;
                            mem_wdata[SLINK_LO +: SV]              = NONE;
                            mem_wmask[SLINK_LO +: SV]              = '1;
                            sub_next    = slot_ix;
                            ri_ret_next = tsrp_pkg::S_DONE;
                            state_next  = tsrp_pkg::S_RI_A;
                        end
                    end
                    tsrp_pkg::MODE_DESTROY:
                    begin
                        if (!slot_ok || !used_reg[slot_ix])
                        begin
                            status_next = tsrp_pkg::STATUS_IGNORED;
                        end
                        else
                        begin
                            sub_next    = slot_ix;
                            rr_ret_next = tsrp_pkg::S_DS_B;
                            state_next  = tsrp_pkg::S_RR_A;
                        end
                    end
                    tsrp_pkg::MODE_WAKE:
                    begin
                        if (!slot_ok || !used_reg[slot_ix] ||
                            stat_reg[slot_ix] != tsrp_pkg::TS_SLEEP)
                        begin
                            status_next = tsrp_pkg::STATUS_IGNORED;
                        end
                        else
                        begin
                            sub_next    = slot_ix;
                            sr_ret_next = tsrp_pkg::S_WK_B;
                            state_next  = tsrp_pkg::S_SR_A;
                        end
                    end
                    tsrp_pkg::MODE_YIELD:
                    begin
                        if (!cur_real || stat_reg[cur_ix] == tsrp_pkg::TS_ZOMBIE)
                        begin
                            status_next = tsrp_pkg::STATUS_IGNORED;
                        end
                        else
                        begin
                            stat_next[cur_ix] = tsrp_pkg::TS_READY;
                            sub_next    = cur_ix;
                            ri_ret_next = tsrp_pkg::S_DONE;
                            state_next  = tsrp_pkg::S_RI_A;
                        end
                    end
                    tsrp_pkg::MODE_EXIT:
                    begin
                        if (!cur_real)
                        begin
                            status_next = tsrp_pkg::STATUS_IGNORED;
                        end
                        else
                        begin
                            stat_next[cur_ix] = tsrp_pkg::TS_ZOMBIE;
                            sub_next    = cur_ix;
                            rr_ret_next = tsrp_pkg::S_DONE;
                            state_next  = tsrp_pkg::S_RR_A;
                        end
                    end
                    tsrp_pkg::MODE_SLEEP:
                    begin
                        if (!cur_real || stat_reg[cur_ix] == tsrp_pkg::TS_ZOMBIE)
                        begin
                            status_next = tsrp_pkg::STATUS_IGNORED;
                        end
                        else
                        begin
                            sub_next    = cur_ix;
                            rr_ret_next = tsrp_pkg::S_SL_B;
                            state_next  = tsrp_pkg::S_RR_A;
                        end
                    end
                    tsrp_pkg::MODE_TICK:
                    begin
                        tick_next  = tick_reg + 64'd1;
                        wk_next    = sfirst_reg;
                        wk_k_next  = '0;
                        state_next = tsrp_pkg::S_TK_A;
                    end
                    default:
                    begin
                        status_next = tsrp_pkg::STATUS_IGNORED;
                    end
                endcase
            end

            // ring insert at the tail
            tsrp_pkg::S_RI_A:
            begin
                if (queued_reg[sub_reg])
                begin
                    state_next = ri_ret_reg;
                end
                else
                begin
                    queued_next[sub_reg] = 1'b1;
                    if (empty_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = sub_reg;
                        mem_wdata[NEXT_LO +: SW] = sub_reg;
                        mem_wmask[NEXT_LO +: SW] = '1;
                        mem_wdata[PREV_LO +: SW] = sub_reg;
                        mem_wmask[PREV_LO +: SW] = '1;
                        head_next  = sub_reg;
                        empty_next = 1'b0;
                        state_next = ri_ret_reg;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = head_reg;
                        state_next = tsrp_pkg::S_RI_B;
                    end
                end
            end
            tsrp_pkg::S_RI_B:
            begin
                tail_next = mem_q[PREV_LO +: SW];
                mem_we    = 1'b1;
                mem_waddr = sub_reg;
                mem_wdata[NEXT_LO +: SW] = head_reg;
                mem_wmask[NEXT_LO +: SW] = '1;
                mem_wdata[PREV_LO +: SW] = mem_q[PREV_LO +: SW];
                mem_wmask[PREV_LO +: SW] = '1;
                state_next = tsrp_pkg::S_RI_C;
            end
            tsrp_pkg::S_RI_C:
            begin
                mem_we    = 1'b1;
                mem_waddr = tail_reg;
                mem_wdata[NEXT_LO +: SW] = sub_reg;
                mem_wmask[NEXT_LO +: SW] = '1;
                state_next = tsrp_pkg::S_RI_D;
            end
            tsrp_pkg::S_RI_D:
            begin
                mem_we    = 1'b1;
                mem_waddr = head_reg;
                mem_wdata[PREV_LO +: SW] = sub_reg;
                mem_wmask[PREV_LO +: SW] = '1;
                state_next = ri_ret_reg;
            end

            // ring remove
            tsrp_pkg::S_RR_A:
            begin
                if (!queued_reg[sub_reg])
                begin
                    state_next = rr_ret_reg;
                end
                else
                begin
                    queued_next[sub_reg] = 1'b0;
                    mem_re     = 1'b1;
                    mem_raddr  = sub_reg;
                    state_next = tsrp_pkg::S_RR_B;
                end
            end
            tsrp_pkg::S_RR_B:
            begin
                rn_next = mem_q[NEXT_LO +: SW];
                rp_next = mem_q[PREV_LO +: SW];
                if (mem_q[NEXT_LO +: SW] == sub_reg)
                begin
                    empty_next = 1'b1;
                    head_next  = '0;
                    state_next = rr_ret_reg;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = mem_q[PREV_LO +: SW];
                    mem_wdata[NEXT_LO +: SW] = mem_q[NEXT_LO +: SW];
                    mem_wmask[NEXT_LO +: SW] = '1;
                    state_next = tsrp_pkg::S_RR_C;
                end
            end
            tsrp_pkg::S_RR_C:
            begin
                mem_we    = 1'b1;
                mem_waddr = rn_reg;
                mem_wdata[PREV_LO +: SW] = rp_reg;
                mem_wmask[PREV_LO +: SW] = '1;
                if (head_reg == sub_reg)
                begin
                    head_next = rn_reg;
                end
                state_next = rr_ret_reg;
            end

            // sleep list unlink
            tsrp_pkg::S_SR_A:
            begin
                sp_prev_next = NONE;
                sp_cur_next  = sfirst_reg;
                sp_k_next    = '0;
                state_next   = tsrp_pkg::S_SR_B;
            end
            tsrp_pkg::S_SR_B:
            begin
                if ((32'(sp_k_reg) < NUM_SLOTS) && (32'(sp_cur_reg) < NUM_SLOTS))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = sp_cur_reg[SW-1:0];
                    state_next = tsrp_pkg::S_SR_C;
                end
                else
                begin
                    state_next = tsrp_pkg::S_SR_E;
                end
            end
            tsrp_pkg::S_SR_C:
            begin
                if (sp_cur_reg == {1'b0, sub_reg})
                begin
                    if (32'(sp_prev_reg) < NUM_SLOTS)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = sp_prev_reg[SW-1:0];
                        mem_wdata[SLINK_LO +: SV] = mem_q[SLINK_LO +: SV];
                        mem_wmask[SLINK_LO +: SV] = '1;
                    end
                    else
                    begin
                        sfirst_next = mem_q[SLINK_LO +: SV];
                    end
                    state_next = tsrp_pkg::S_SR_E;
                end
                else
                begin
                    sp_prev_next = sp_cur_reg;
                    sp_cur_next  = mem_q[SLINK_LO +: SV];
                    sp_k_next    = sp_k_reg + 1'b1;
                    state_next   = tsrp_pkg::S_SR_B;
                end
            end
            tsrp_pkg::S_SR_E:
            begin
                mem_we    = 1'b1;
                mem_waddr = sub_reg;
                mem_wdata[SLINK_LO +: SV] = NONE;
                mem_wmask[SLINK_LO +: SV] = '1;
                state_next = sr_ret_reg;
            end

            // destroy tail
            tsrp_pkg::S_DS_B:
            begin
                used_next[sub_reg] = 1'b0;
                stat_next[sub_reg] = tsrp_pkg::TS_READY;
                sr_ret_next = tsrp_pkg::S_DONE;
                state_next  = tsrp_pkg::S_SR_A;
            end

            // wake tail
            tsrp_pkg::S_WK_B:
            begin
                if (!queued_reg[sub_reg])
                begin
                    stat_next[sub_reg] = tsrp_pkg::TS_READY;
                    ri_ret_next = tsrp_pkg::S_DONE;
                    state_next  = tsrp_pkg::S_RI_A;
                end
                else
                begin
                    state_next = tsrp_pkg::S_DONE;
                end
            end

            // sleep: wake time then push to the front
            tsrp_pkg::S_SL_B:
            begin
                stat_next[sub_reg] = tsrp_pkg::TS_SLEEP;
                mem_we    = 1'b1;
                mem_waddr = sub_reg;
                mem_wdata[WAKE_LO +: tsrp_pkg::WAKE_W] = tick_reg + 64'(cmd_reg.sleep_ticks);
                mem_wmask[WAKE_LO +: tsrp_pkg::WAKE_W] = '1;
                sr_ret_next = tsrp_pkg::S_SL_C;
                state_next  = tsrp_pkg::S_SR_A;
            end
            tsrp_pkg::S_SL_C:
            begin
                mem_we    = 1'b1;
                mem_waddr = sub_reg;
                mem_wdata[SLINK_LO +: SV] = sfirst_reg;
                mem_wmask[SLINK_LO +: SV] = '1;
                sfirst_next = {1'b0, sub_reg};
                state_next  = tsrp_pkg::S_DONE;
            end

            // tick: walk the sleep list
            tsrp_pkg::S_TK_A:
            begin
                if ((32'(wk_k_reg) < NUM_SLOTS) && (32'(wk_reg) < NUM_SLOTS))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = wk_reg[SW-1:0];
                    state_next = tsrp_pkg::S_TK_B;
                end
                else
                begin
                    state_next = tsrp_pkg::S_PK_A;
                end
            end
            tsrp_pkg::S_TK_B:
            begin
                wk_nx_next = mem_q[SLINK_LO +: SV];
                if ((mem_q[WAKE_LO +: tsrp_pkg::WAKE_W] <= tick_reg) &&
                    (stat_reg[wk_reg[SW-1:0]] == tsrp_pkg::TS_SLEEP))
                begin
                    sub_next    = wk_reg[SW-1:0];
                    sr_ret_next = tsrp_pkg::S_TK_C;
                    state_next  = tsrp_pkg::S_SR_A;
                end
                else
                begin
                    wk_next    = mem_q[SLINK_LO +: SV];
                    wk_k_next  = wk_k_reg + 1'b1;
                    state_next = tsrp_pkg::S_TK_A;
                end
            end
            tsrp_pkg::S_TK_C:
            begin
                if (!queued_reg[sub_reg])
                begin
                    stat_next[sub_reg] = tsrp_pkg::TS_READY;
                    ri_ret_next = tsrp_pkg::S_TK_D;
                    state_next  = tsrp_pkg::S_RI_A;
                end
                else
                begin
                    state_next = tsrp_pkg::S_TK_D;
                end
            end
            tsrp_pkg::S_TK_D:
            begin
                wk_next    = wk_nx_reg;
                wk_k_next  = wk_k_reg + 1'b1;
                state_next = tsrp_pkg::S_TK_A;
            end

            // tick: pick the next task
            tsrp_pkg::S_PK_A:
            begin
                if (empty_reg)
                begin
                    pk_next    = NONE;
                    state_next = tsrp_pkg::S_UPD;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = head_reg;
                    state_next = policy_reg ? tsrp_pkg::S_PK_B : tsrp_pkg::S_PK_R;
                end
            end
            tsrp_pkg::S_PK_R:
            begin
                pk_next    = {1'b0, head_reg};
                head_next  = mem_q[NEXT_LO +: SW];
                state_next = tsrp_pkg::S_UPD;
            end
            tsrp_pkg::S_PK_B:
            begin
                best_next  = head_reg;
                bprio_next = mem_q[0 +: tsrp_pkg::PRIO_W];
                bcpu_next  = mem_q[CPU_LO +: tsrp_pkg::CPU_W];
                pc_next    = mem_q[NEXT_LO +: SW];
                pk_k_next  = '0;
                state_next = tsrp_pkg::S_PK_C;
            end
            tsrp_pkg::S_PK_C:
            begin
                if ((32'(pk_k_reg) < NUM_SLOTS) && (pc_reg != head_reg))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = pc_reg;
                    state_next = tsrp_pkg::S_PK_D;
                end
                else
                begin
                    pk_next    = {1'b0, best_reg};
                    state_next = tsrp_pkg::S_UPD;
                end
            end
            tsrp_pkg::S_PK_D:
            begin
                if ((mem_q[0 +: tsrp_pkg::PRIO_W] > bprio_reg) ||
                    ((mem_q[0 +: tsrp_pkg::PRIO_W] == bprio_reg) &&
                     (mem_q[CPU_LO +: tsrp_pkg::CPU_W] < bcpu_reg)))
                begin
                    best_next  = pc_reg;
                    bprio_next = mem_q[0 +: tsrp_pkg::PRIO_W];
                    bcpu_next  = mem_q[CPU_LO +: tsrp_pkg::CPU_W];
                end
                pc_next    = mem_q[NEXT_LO +: SW];
                pk_k_next  = pk_k_reg + 1'b1;
                state_next = tsrp_pkg::S_PK_C;
            end

            // tick: accounting
            tsrp_pkg::S_UPD:
            begin
                cur_next      = pk_reg;
                switched_next = (cur_reg != pk_reg);
                if (cur_reg != pk_reg)
                begin
                    switch_next = switch_reg + 32'd1;
                end
                if (32'(pk_reg) < NUM_SLOTS)
                begin
                    busy_cnt_next = busy_cnt_reg + 32'd1;
                    mem_re        = 1'b1;
                    mem_raddr     = pk_reg[SW-1:0];
                    state_next    = tsrp_pkg::S_UP_B;
                end
                else
                begin
                    idle_next  = idle_reg + 32'd1;
                    state_next = tsrp_pkg::S_DONE;
                end
            end
            tsrp_pkg::S_UP_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = pk_reg[SW-1:0];
                mem_wdata[CPU_LO +: tsrp_pkg::CPU_W] = mem_q[CPU_LO +: tsrp_pkg::CPU_W] + 32'd1;
                mem_wmask[CPU_LO +: tsrp_pkg::CPU_W] = '1;
                stat_next[pk_reg[SW-1:0]] = tsrp_pkg::TS_READY;
                sub_next    = pk_reg[SW-1:0];
                ri_ret_next = tsrp_pkg::S_DONE;
                state_next  = tsrp_pkg::S_RI_A;
            end

            tsrp_pkg::S_DONE:
            begin
                state_next = tsrp_pkg::S_IDLE;
            end

            default:
            begin
                state_next = tsrp_pkg::S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tsrp_pkg::S_IDLE;
            ri_ret_reg   <= tsrp_pkg::S_IDLE;
            rr_ret_reg   <= tsrp_pkg::S_IDLE;
            sr_ret_reg   <= tsrp_pkg::S_IDLE;
            status_reg   <= tsrp_pkg::STATUS_DONE;
            switched_reg <= 1'b0;
            policy_reg   <= 1'b0;
            used_reg     <= '0;
            queued_reg   <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                stat_reg[i] <= tsrp_pkg::TS_READY;
            end
            head_reg     <= '0;
            empty_reg    <= 1'b1;
            sfirst_reg   <= NONE;
            cur_reg      <= NONE;
            tick_reg     <= '0;
            switch_reg   <= '0;
            idle_reg     <= '0;
            busy_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ri_ret_reg   <= ri_ret_next;
            rr_ret_reg   <= rr_ret_next;
            sr_ret_reg   <= sr_ret_next;
            status_reg   <= status_next;
            switched_reg <= switched_next;
            if (cfg_wr)
            begin
                policy_reg <= pwdata[0];
            end
            used_reg     <= used_next;
            queued_reg   <= queued_next;
            stat_reg     <= stat_next;
            head_reg     <= head_next;
            empty_reg    <= empty_next;
            sfirst_reg   <= sfirst_next;
            cur_reg      <= cur_next;
            tick_reg     <= tick_next;
            switch_reg   <= switch_next;
            idle_reg     <= idle_next;
            busy_cnt_reg <= busy_cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        sub_reg     <= sub_next;
        tail_reg    <= tail_next;
        rn_reg      <= rn_next;
        rp_reg      <= rp_next;
        sp_prev_reg <= sp_prev_next;
        sp_cur_reg  <= sp_cur_next;
        sp_k_reg    <= sp_k_next;
        wk_reg      <= wk_next;
        wk_nx_reg   <= wk_nx_next;
        wk_k_reg    <= wk_k_next;
        best_reg    <= best_next;
        pc_reg      <= pc_next;
        bprio_reg   <= bprio_next;
        bcpu_reg    <= bcpu_next;
        pk_k_reg    <= pk_k_next;
        pk_reg      <= pk_next;
    end

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted event did not start work");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("result transfer not followed by idle");

    a_empty_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (empty_reg && !busy) |-> (queued_reg == '0))
        else $error("empty ring with queued slots");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/tsrp_ram.sv
`default_nettype none

module tsrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wmask,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // masked write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= (mem[waddr] & ~wmask) | (wdata & wmask);
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam logic [4:0] NONE = 5'd16;
    localparam logic [2:0] MODE_BAD = 3'd7;
    localparam logic [2:0] ADDR_POLICY = 3'd0;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 140;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    tsrp_pkg::cmd_t cmd = '0;
    logic done;
    tsrp_pkg::result_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    tsrp_pkg::cmd_t pending_cmds[$];
    tsrp_pkg::result_t expected_results[$];
    int sender_idle_pct = 0;
    int errors = 0;
    int cycles = 0;

    task_scheduler_rr_priority dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always #2 clk = ~clk;

    // scheduler state mirror
    logic        policy_prio = 1'b0;
    logic        used_q[SLOTS];
    logic [1:0]  task_state[SLOTS];
    logic [7:0]  task_prio[SLOTS];
    logic [31:0] task_cpu[SLOTS];
    logic [63:0] task_wake[SLOTS];
    logic        in_ring[SLOTS];
    logic [3:0]  ring_fwd[SLOTS];
    logic [3:0]  ring_back[SLOTS];
    logic [3:0]  ring_top = '0;
    logic        ring_none = 1'b1;
    logic [4:0]  sleeper_next[SLOTS];
    logic [4:0]  sleeper_top = NONE;
    logic [4:0]  running = NONE;
    logic [63:0] ticks_seen = '0;
    logic [31:0] switches_seen = '0;
    logic [31:0] idle_ticks = '0;
    logic [31:0] busy_ticks = '0;

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            used_q[i] = 1'b0;
            task_state[i] = tsrp_pkg::TS_READY;
            in_ring[i] = 1'b0;
            sleeper_next[i] = NONE;
        end
    end

    function automatic void ring_append(logic [3:0] s);
        logic [3:0] tail;
        if (in_ring[s])
            return;
        in_ring[s] = 1'b1;
        if (ring_none)
        begin
            ring_fwd[s] = s;
            ring_back[s] = s;
            ring_top = s;
            ring_none = 1'b0;
            return;
        end
        tail = ring_back[ring_top];
        ring_fwd[s] = ring_top;
        ring_back[s] = tail;
        ring_fwd[tail] = s;
        ring_back[ring_top] = s;
    endfunction

    function automatic void ring_unlink(logic [3:0] s);
        logic [3:0] n;
        logic [3:0] p;
        if (!in_ring[s])
            return;
        in_ring[s] = 1'b0;
        n = ring_fwd[s];
        p = ring_back[s];
        if (n == s)
        begin
            ring_none = 1'b1;
            ring_top = '0;
            return;
        end
        ring_fwd[p] = n;
        ring_back[n] = p;
        if (ring_top == s)
            ring_top = n;
    endfunction

    function automatic void sleeper_unlink(logic [3:0] s);
        logic [4:0] prev;
        logic [4:0] c;
        prev = NONE;
        c = sleeper_top;
        for (int k = 0; k < SLOTS && c < NONE; k++)
        begin
            if (c[3:0] == s)
            begin
                if (prev < NONE)
                    sleeper_next[prev[3:0]] = sleeper_next[s];
                else
                    sleeper_top = sleeper_next[s];
                break;
            end
            prev = c;
            c = sleeper_next[c[3:0]];
        end
        sleeper_next[s] = NONE;
    endfunction

    function automatic void requeue(logic [3:0] s);
        if (in_ring[s])
            return;
        task_state[s] = tsrp_pkg::TS_READY;
        ring_append(s);
    endfunction

    function automatic logic [4:0] choose_next();
        logic [3:0] best;
        logic [3:0] c;
        if (ring_none)
            return NONE;
        best = ring_top;
        if (policy_prio)
        begin
            c = ring_fwd[ring_top];
            for (int k = 0; k < SLOTS && c != ring_top; k++)
            begin
                if (task_prio[c] > task_prio[best] ||
                    (task_prio[c] == task_prio[best] && task_cpu[c] < task_cpu[best]))
                    best = c;
                c = ring_fwd[c];
            end
        end
        else
            ring_top = ring_fwd[ring_top];
        return {1'b0, best};
    endfunction

    function automatic logic run_tick();
        logic [4:0] s;
        logic [4:0] nx;
        logic [4:0] prev_run;
        logic [4:0] pk;
        ticks_seen++;
        s = sleeper_top;
        for (int k = 0; k < SLOTS && s < NONE; k++)
        begin
            nx = sleeper_next[s[3:0]];
            if (task_wake[s[3:0]] <= ticks_seen &&
                task_state[s[3:0]] == tsrp_pkg::TS_SLEEP)
            begin
                sleeper_unlink(s[3:0]);
                requeue(s[3:0]);
            end
            s = nx;
        end
        prev_run = running;
        pk = choose_next();
        running = pk;
        if (pk < NONE)
        begin
            task_cpu[pk[3:0]]++;
            busy_ticks++;
            task_state[pk[3:0]] = tsrp_pkg::TS_READY;
            ring_append(pk[3:0]);
        end
        else
            idle_ticks++;
        if (prev_run != pk)
        begin
            switches_seen++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // expected outcome of one scheduler event
    function automatic tsrp_pkg::result_t schedule_event(tsrp_pkg::cmd_t c);
        tsrp_pkg::result_t r;
        logic [3:0] s;
        logic [3:0] cs;
        logic cur_real;
        r = '0;
        r.status = tsrp_pkg::STATUS_DONE;
        s = c.task_slot;
        cs = running[3:0];
        cur_real = running < NONE && used_q[cs];
        case (c.mode)
            tsrp_pkg::MODE_CREATE:
                if (used_q[s])
                    r.status = tsrp_pkg::STATUS_OCCUPIED;
                else
                begin
                    used_q[s] = 1'b1;
                    task_state[s] = tsrp_pkg::TS_READY;
                    task_prio[s] = c.task_priority;
                    task_cpu[s] = '0;
                    in_ring[s] = 1'b0;
                    sleeper_next[s] = NONE;
                    ring_append(s);
                end
            tsrp_pkg::MODE_DESTROY:
                if (!used_q[s])
                    r.status = tsrp_pkg::STATUS_IGNORED;
                else
                begin
                    ring_unlink(s);
                    sleeper_unlink(s);
                    used_q[s] = 1'b0;
                    task_state[s] = tsrp_pkg::TS_READY;
                end
            tsrp_pkg::MODE_WAKE:
                if (!used_q[s] || task_state[s] != tsrp_pkg::TS_SLEEP)
                    r.status = tsrp_pkg::STATUS_IGNORED;
                else
                begin
                    sleeper_unlink(s);
                    requeue(s);
                end
            tsrp_pkg::MODE_YIELD:
                if (!cur_real || task_state[cs] == tsrp_pkg::TS_ZOMBIE)
                    r.status = tsrp_pkg::STATUS_IGNORED;
                else
                begin
                    task_state[cs] = tsrp_pkg::TS_READY;
                    ring_append(cs);
                end
            tsrp_pkg::MODE_EXIT:
                if (!cur_real)
                    r.status = tsrp_pkg::STATUS_IGNORED;
                else
                begin
                    task_state[cs] = tsrp_pkg::TS_ZOMBIE;
                    ring_unlink(cs);
                end
            tsrp_pkg::MODE_SLEEP:
                if (!cur_real || task_state[cs] == tsrp_pkg::TS_ZOMBIE)
                    r.status = tsrp_pkg::STATUS_IGNORED;
                else
                begin
                    ring_unlink(cs);
                    task_state[cs] = tsrp_pkg::TS_SLEEP;
                    task_wake[cs] = ticks_seen + {32'd0, c.sleep_ticks};
                    sleeper_unlink(cs);
                    sleeper_next[cs] = sleeper_top;
                    sleeper_top = {1'b0, cs};
                end
            tsrp_pkg::MODE_TICK:
                r.switched = run_tick();
            default:
                r.status = tsrp_pkg::STATUS_IGNORED;
        endcase
        r.running_task = running < NONE ? running[3:0] : 4'd0;
        r.running_idle = running < NONE ? 1'b0 : 1'b1;
        r.tick_count = ticks_seen;
        r.switch_count = switches_seen;
        r.idle_count = idle_ticks;
        r.busy_count = busy_ticks;
        return r;
    endfunction

    // command driver
    always @(posedge clk)
    begin
        if (rst_n && (!start || !busy))
        begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                start <= 1'b1;
                cmd <= pending_cmds.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // prediction on each accepted transfer, checking on each result
    always @(posedge clk)
    begin
        tsrp_pkg::result_t exp_r;
        if (psel && penable && pwrite && pready && paddr == ADDR_POLICY)
            policy_prio <= pwdata[0];
        if (rst_n && start && !busy)
            expected_results.push_back(schedule_event(cmd));
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (result.status !== exp_r.status)
                begin
                    $error("status exp %0d got %0d", exp_r.status, result.status);
                    errors++;
                end
                if (result.running_task !== exp_r.running_task)
                begin
                    $error("running_task exp %0d got %0d", exp_r.running_task,
                        result.running_task);
                    errors++;
                end
                if (result.running_idle !== exp_r.running_idle)
                begin
                    $error("running_idle exp %0d got %0d", exp_r.running_idle,
                        result.running_idle);
                    errors++;
                end
                if (result.switched !== exp_r.switched)
                begin
                    $error("switched exp %0d got %0d", exp_r.switched, result.switched);
                    errors++;
                end
                if (result.tick_count !== exp_r.tick_count)
                begin
                    $error("tick_count exp %0d got %0d", exp_r.tick_count,
                        result.tick_count);
                    errors++;
                end
                if (result.switch_count !== exp_r.switch_count)
                begin
                    $error("switch_count exp %0d got %0d", exp_r.switch_count,
                        result.switch_count);
                    errors++;
                end
                if (result.idle_count !== exp_r.idle_count)
                begin
                    $error("idle_count exp %0d got %0d", exp_r.idle_count,
                        result.idle_count);
                    errors++;
                end
                if (result.busy_count !== exp_r.busy_count)
                begin
                    $error("busy_count exp %0d got %0d", exp_r.busy_count,
                        result.busy_count);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("task_scheduler_rr_priority: mismatch");
            $finish;
        end
    end

    function automatic tsrp_pkg::cmd_t make_cmd(logic [2:0] m, logic [3:0] s,
        logic [7:0] p, logic [31:0] t);
        tsrp_pkg::cmd_t c;
        c.mode = m;
        c.task_slot = s;
        c.task_priority = p;
        c.sleep_ticks = t;
        return c;
    endfunction

    // random event mix weighted towards a busy, well-populated table
    function automatic tsrp_pkg::cmd_t random_cmd();
        int pick;
        int sel;
        logic [2:0] m;
        logic [3:0] s;
        logic [7:0] p;
        logic [31:0] t;
        pick = $urandom_range(99);
        if (pick < 15)      m = tsrp_pkg::MODE_CREATE;
        else if (pick < 22) m = tsrp_pkg::MODE_DESTROY;
        else if (pick < 30) m = tsrp_pkg::MODE_WAKE;
        else if (pick < 38) m = tsrp_pkg::MODE_YIELD;
        else if (pick < 43) m = tsrp_pkg::MODE_EXIT;
        else if (pick < 53) m = tsrp_pkg::MODE_SLEEP;
        else if (pick < 98) m = tsrp_pkg::MODE_TICK;
        else                m = MODE_BAD;
        s = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5));
        p = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(2));
        sel = $urandom_range(9);
        if (sel < 7)      t = $urandom_range(6);
        else if (sel < 9) t = $urandom;
        else              t = 32'hFFFF_FFFF;
        return make_cmd(m, s, p, t);
    endfunction

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_policy(logic v);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_POLICY;
        pwdata <= {31'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and the odd corners of the event set
        write_policy(1'b0);
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_TICK, 4'd0, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_YIELD, 4'd0, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_CREATE, 4'd0, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_CREATE, 4'd15, 8'd255, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_CREATE, 4'd0, 8'd7, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_TICK, 4'd0, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_TICK, 4'd0, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_SLEEP, 4'd0, 8'd0, 32'd2));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_SLEEP, 4'd0, 8'd0, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_YIELD, 4'd0, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_WAKE, 4'd15, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_TICK, 4'd0, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_SLEEP, 4'd0, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_TICK, 4'd0, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_EXIT, 4'd0, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_YIELD, 4'd0, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_EXIT, 4'd0, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_TICK, 4'd0, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_DESTROY, 4'd15, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_DESTROY, 4'd9, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_WAKE, 4'd9, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_CREATE, 4'd15, 8'd1, 32'd0));
        pending_cmds.push_back(make_cmd(MODE_BAD, 4'd15, 8'd255, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_TICK, 4'd0, 8'd0, 32'd0));
        pending_cmds.push_back(make_cmd(tsrp_pkg::MODE_TICK, 4'd0, 8'd0, 32'd0));
        wait_idle();

        // random phases, policy alternating, sender gaps shifting
        for (int ph = 0; ph < 6; ph++)
        begin
            write_policy(ph[0] ? 1'b0 : 1'b1);
            sender_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 83 : 0;
            for (int i = 0; i < 305; i++)
                pending_cmds.push_back(random_cmd());
            wait_idle();
        end

        if (errors == 0)
            $display("task_scheduler_rr_priority: match");
        else
            $display("task_scheduler_rr_priority: mismatch");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/tsrp_pkg.sv
hw/rtl/tsrp_ram.sv
hw/rtl/task_scheduler_rr_priority.sv
dv/testbench.sv
